/* src/cbm_pkg.sv */
// ----------------------------------------------------------------------------
// cbm_pkg
// shared beat types, mapper register codes and fixed constants for the
// cartridge bank mapper
// ----------------------------------------------------------------------------
package cbm_pkg;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int PAGE_W     = 8;
    localparam int BANK_BITS  = 14;
    localparam int ROM_ADDR_W = 22;
    localparam int NUM_PAGES  = 3;

    localparam logic [ADDR_W-1:0]    ROM_WINDOW_MASK = 16'h7fff;
    localparam logic [ADDR_W-1:0]    MAPPER_REG_BASE = 16'hfffc;
    localparam int                   RAM_ENABLE_BIT  = 3;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // low two address bits of a mapper register write
    typedef enum logic [1:0] {
        SEL_CONTROL = 2'd0,
        SEL_PAGE0   = 2'd1,
        SEL_PAGE1   = 2'd2,
        SEL_PAGE2   = 2'd3
    } reg_sel_t;

    typedef struct packed {
        logic              op;
        logic              cart_select_n;
        logic              slot2_select_n;
        logic              slot1_select_n;
        logic [ADDR_W-1:0] bus_address;
        logic [DATA_W-1:0] write_data;
    } in_beat_t;

    typedef struct packed {
        logic                  rom_read;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic                  ram_read;
        logic [DATA_W-1:0]     ram_data;
    } out_beat_t;

    // one access to the cartridge ram
    typedef struct packed {
        logic                 rd_en;
        logic                 wr_en;
        logic [BANK_BITS-1:0] addr;
        logic [DATA_W-1:0]    wdata;
    } ram_req_t;

endpackage

/* src/cbm_ram.sv */
// ----------------------------------------------------------------------------
// cbm_ram
// cartridge ram: single port synchronous array with registered read data
// ----------------------------------------------------------------------------
module cbm_ram #(
    parameter int RAM_DEPTH = 16384
) (
    input  logic                      clk,
    input  cbm_pkg::ram_req_t         req,
    output logic [cbm_pkg::DATA_W-1:0] rdata
);

    localparam int IDX_W = $clog2(RAM_DEPTH);
    localparam int RED_W = cbm_pkg::BANK_BITS + 4;

    logic [cbm_pkg::DATA_W-1:0] mem [RAM_DEPTH];
    logic [cbm_pkg::DATA_W-1:0] rdata_reg;
    logic [RED_W-1:0]           rem;
    logic [IDX_W-1:0]           index;

    // fold the 14-bit window offset into the depth, four compare/subtract steps
    always_comb
    begin
        rem = RED_W'(req.addr);
        for (int k = 3; k >= 0; k--)
        begin
            if (rem >= (RED_W'(RAM_DEPTH) << k))
            begin
                rem = rem - (RED_W'(RAM_DEPTH) << k);
            end
        end
        index = rem[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[index] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[index];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/cartridge_bank_mapper_top.sv */
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_top
// cartridge rom/ram bank mapper: maps each cpu bus access onto a physical
// rom address or the cartridge ram, and takes mapper register writes
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_stall    in_beat  (cbm_pkg::in_beat_t)
//  out       source     out_valid / out_stall  out_beat (cbm_pkg::out_beat_t)
//  cfg       sink       cfg_valid / cfg_ready  cfg_data (mapper_enable)
//
//  one beat per cycle while out_stall does not hold the output; each input beat gives its result beat the next cycle
//  the ram read port and the output register share the same edge, so the
//  ram read data arrives together with its result beat
//  rst_n clears the output valid, mapper enable and control byte, and sets pages 0/1/2 to 0/1/2
//  ram contents are not cleared; no sweep after reset
//  out_stall holds the output register and backs up to in_stall directly
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_top #(
    parameter int ROM_ADDR_BITS = 22,
    parameter int RAM_DEPTH     = 16384
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  cbm_pkg::in_beat_t  in_beat,
    output logic               out_valid,
    input  logic               out_stall,
    output cbm_pkg::out_beat_t out_beat,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);

    localparam logic [cbm_pkg::ROM_ADDR_W-1:0] ROM_MASK =
        cbm_pkg::ROM_ADDR_W'((64'(1) << ROM_ADDR_BITS) - 64'(1));

    // mapper registers
    logic                       mapper_enable_reg;
    logic [cbm_pkg::PAGE_W-1:0] control_reg;
    logic [cbm_pkg::PAGE_W-1:0] control_next;
    logic [cbm_pkg::PAGE_W-1:0] page_reg  [cbm_pkg::NUM_PAGES];
    logic [cbm_pkg::PAGE_W-1:0] page_next [cbm_pkg::NUM_PAGES];

    // output stage
    logic                           out_valid_reg;
    logic                           rom_rd_reg;
    logic                           rom_rd_next;
    logic [cbm_pkg::ROM_ADDR_W-1:0] rom_addr_reg;
    logic [cbm_pkg::ROM_ADDR_W-1:0] rom_addr_next;
    logic                           ram_rd_reg;
    logic                           ram_rd_next;

    // decode
    logic                       accept;
    logic                       cart_on;
    logic                       slot2;
    logic                       slot1;
    logic                       bus_write;
    logic                       reg_hit;
    logic [cbm_pkg::PAGE_W-1:0] win_page;
    logic [5:0]                 page_offset;
    logic [cbm_pkg::PAGE_W-1:0] page_wdata;
    cbm_pkg::reg_sel_t          reg_sel;
    cbm_pkg::ram_req_t          ram_req;
    logic [cbm_pkg::DATA_W-1:0] ram_rdata;

    // a beat leaves the input side whenever the output register is free or
    // being emptied in the same cycle
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign cart_on   = !in_beat.cart_select_n;
    assign slot2     = !in_beat.slot2_select_n;
    assign slot1     = !in_beat.slot1_select_n;
    assign bus_write = accept && cart_on && (in_beat.op == cbm_pkg::OP_WRITE)
                       && mapper_enable_reg;
    assign reg_hit   = in_beat.bus_address >= cbm_pkg::MAPPER_REG_BASE;
    assign reg_sel   = cbm_pkg::reg_sel_t'(in_beat.bus_address[1:0]);

    // lower 32 KB: page 0 or page 1 chosen by address bit 14
    assign win_page  = in_beat.bus_address[cbm_pkg::BANK_BITS] ? page_reg[1] : page_reg[0];

    // read mapping: rom address or ram read, from the registers before this beat
    always_comb
    begin
        rom_rd_next   = 1'b0;
        rom_addr_next = '0;
        ram_rd_next   = 1'b0;
        if (cart_on && (in_beat.op == cbm_pkg::OP_READ))
        begin
            if (!mapper_enable_reg)
            begin
                // flat 32 KB rom
                if (slot2)
                begin
                    rom_rd_next   = 1'b1;
                    rom_addr_next = cbm_pkg::ROM_ADDR_W'(in_beat.bus_address
                                                         & cbm_pkg::ROM_WINDOW_MASK);
                end
            end
            else if (slot2)
            begin
                // slot2 wins when both selects are low
                rom_rd_next   = 1'b1;
                rom_addr_next = {win_page, in_beat.bus_address[cbm_pkg::BANK_BITS-1:0]};
            end
            else if (slot1)
            begin
                if (control_reg[cbm_pkg::RAM_ENABLE_BIT])
                begin
                    ram_rd_next = 1'b1;
                end
                else
                begin
                    rom_rd_next   = 1'b1;
                    rom_addr_next = {page_reg[2],
                                     in_beat.bus_address[cbm_pkg::BANK_BITS-1:0]};
                end
            end
        end
        rom_addr_next = rom_addr_next & ROM_MASK;
    end

    // page writes are shifted by (4 - n) * 8 when control bits 1:0 hold n != 0
    assign page_offset = {3'(3'd4 - {1'b0, control_reg[1:0]}), 3'b000};
    assign page_wdata  = (control_reg[1:0] == 2'd0) ? in_beat.write_data
                         : in_beat.write_data + {2'b00, page_offset};

    // mapper register writes at FFFC..FFFF with the mapper enabled, slot selects don't matter
    always_comb
    begin
        control_next = control_reg;
        page_next    = page_reg;
        if (bus_write && reg_hit)
        begin
            unique case (reg_sel)
                cbm_pkg::SEL_CONTROL: control_next = in_beat.write_data;
                cbm_pkg::SEL_PAGE0:   page_next[0] = page_wdata;
                cbm_pkg::SEL_PAGE1:   page_next[1] = page_wdata;
                cbm_pkg::SEL_PAGE2:   page_next[2] = page_wdata;
                default:              control_next = control_reg;
            endcase
        end
    end

    // cartridge ram: read and write never come from the same beat, so the
    // single port needs no forwarding
    always_comb
    begin
        ram_req.rd_en = accept && ram_rd_next;
        ram_req.wr_en = bus_write && slot1 && control_reg[cbm_pkg::RAM_ENABLE_BIT];
        ram_req.addr  = in_beat.bus_address[cbm_pkg::BANK_BITS-1:0];
        ram_req.wdata = in_beat.write_data;
    end

    cbm_ram #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapper_enable_reg <= 1'b0;
            control_reg       <= '0;
            page_reg[0]       <= 8'd0;
            page_reg[1]       <= 8'd1;
            page_reg[2]       <= 8'd2;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mapper_enable_reg <= cfg_data;
            end
            control_reg <= control_next;
            page_reg    <= page_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rom_rd_reg   <= rom_rd_next;
            rom_addr_reg <= rom_addr_next;
            ram_rd_reg   <= ram_rd_next;
        end
    end

    assign out_valid            = out_valid_reg;
    assign out_beat.rom_read    = rom_rd_reg;
    assign out_beat.rom_address = rom_addr_reg;
    assign out_beat.ram_read    = ram_rd_reg;
    assign out_beat.ram_data    = ram_rd_reg ? ram_rdata : '0;

    // an accepted beat always shows up at the output next cycle
    a_accept_to_out : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted beat did not reach the output");

    // a result is never both a rom read and a ram read
    a_one_target : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_beat.rom_read && out_beat.ram_read))
        else $error("rom and ram read in the same result");

    // no rom address without a rom read
    a_rom_addr_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_beat.rom_read) |-> (out_beat.rom_address == '0))
        else $error("rom address set without rom read");

    // rom address stays inside the configured rom size
    a_rom_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_beat.rom_address & ~ROM_MASK) == '0))
        else $error("rom address beyond rom size");

    // a held result keeps its ram data while the output is stalled
    a_ram_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && out_beat.ram_read) |=> $stable(out_beat.ram_data))
        else $error("ram data changed under stall");

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for cartridge_bank_mapper_top: drives bus access beats
// through the stall handshake, predicts every rom/ram lookup from a local
// copy of the mapper registers and cartridge ram, and compares each result
// beat in order; covers disabled and enabled mapping, page offsets and ram
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAM_WORDS      = 16384;
    localparam int IDLE_PERCENT   = 17;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 2;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    cbm_pkg::in_beat_t  in_beat   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    cbm_pkg::out_beat_t out_beat;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_data  = 1'b0;

    // set while both sides run without any idle cycle
    bit          free_run   = 1'b0;
    int unsigned mismatches = 0;
    int unsigned idle_count = 0;

    // local copy of the mapper: enable, control byte, pages and cartridge ram
    logic                       mapper_on;
    logic [cbm_pkg::PAGE_W-1:0] control_reg;
    logic [cbm_pkg::PAGE_W-1:0] page_reg [cbm_pkg::NUM_PAGES];
    logic [cbm_pkg::DATA_W-1:0] ram_image [RAM_WORDS];
    bit                         ram_written [RAM_WORDS];
    int unsigned                written_slots [$];

    // lookups predicted for accepted accesses, oldest first
    cbm_pkg::out_beat_t pending_lookups [$];

    cartridge_bank_mapper_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // lookup prediction
    // ------------------------------------------------------------------------

    // works out the result of one access and applies its writes
    function automatic cbm_pkg::out_beat_t map_access(cbm_pkg::in_beat_t b);
        cbm_pkg::out_beat_t            r;
        logic [cbm_pkg::BANK_BITS-1:0] idx;
        logic [cbm_pkg::PAGE_W-1:0]    page;
        logic [1:0]                    shift_n;
        r   = '0;
        idx = b.bus_address[cbm_pkg::BANK_BITS-1:0];
        if (!b.cart_select_n && b.op == cbm_pkg::OP_READ)
        begin
            if (!mapper_on)
            begin
                // plain 32 kb cartridge: only the lower window answers
                if (!b.slot2_select_n)
                begin
                    r.rom_read    = 1'b1;
                    r.rom_address = cbm_pkg::ROM_ADDR_W'(b.bus_address
                                                         & cbm_pkg::ROM_WINDOW_MASK);
                end
            end
            else if (!b.slot2_select_n)
            begin
                // slot2 wins when both selects are low
                r.rom_read    = 1'b1;
                r.rom_address = {page_reg[b.bus_address[cbm_pkg::BANK_BITS]], idx};
            end
            else if (!b.slot1_select_n)
            begin
                if (control_reg[cbm_pkg::RAM_ENABLE_BIT])
                begin
                    r.ram_read = 1'b1;
                    r.ram_data = ram_image[idx];
                end
                else
                begin
                    r.rom_read    = 1'b1;
                    r.rom_address = {page_reg[2], idx};
                end
            end
        end
        if (!b.cart_select_n && b.op == cbm_pkg::OP_WRITE && mapper_on)
        begin
            if (!b.slot1_select_n && control_reg[cbm_pkg::RAM_ENABLE_BIT])
            begin
                ram_image[idx] = b.write_data;
                if (!ram_written[idx])
                begin
                    ram_written[idx] = 1'b1;
                    written_slots.push_back(32'(idx));
                end
            end
            // register writes land whatever the slot selects say
            if (b.bus_address >= cbm_pkg::MAPPER_REG_BASE)
            begin
                shift_n = control_reg[1:0];
                page    = b.write_data;
                if (shift_n != 2'd0)
                    page = b.write_data
                           + cbm_pkg::PAGE_W'({3'd4 - {1'b0, shift_n}, 3'b000});
                case (cbm_pkg::reg_sel_t'(b.bus_address[1:0]))
                    cbm_pkg::SEL_CONTROL: control_reg = b.write_data;
                    cbm_pkg::SEL_PAGE0:   page_reg[0] = page;
                    cbm_pkg::SEL_PAGE1:   page_reg[1] = page;
                    cbm_pkg::SEL_PAGE2:   page_reg[2] = page;
                endcase
            end
        end
        return r;
    endfunction

    // ram entries never written are never read: move such a read onto a
    // written entry, or turn it into a read with no window selected
    function automatic cbm_pkg::in_beat_t steer_off_blank(cbm_pkg::in_beat_t b);
        cbm_pkg::in_beat_t s;
        s = b;
        if (mapper_on && !s.cart_select_n && s.op == cbm_pkg::OP_READ &&
            s.slot2_select_n && !s.slot1_select_n &&
            control_reg[cbm_pkg::RAM_ENABLE_BIT] &&
            !ram_written[s.bus_address[cbm_pkg::BANK_BITS-1:0]])
        begin
            if (written_slots.size() != 0)
                s.bus_address[cbm_pkg::BANK_BITS-1:0] = cbm_pkg::BANK_BITS'(
                    written_slots[$urandom_range(0, written_slots.size() - 1)]);
            else
                s.slot1_select_n = 1'b1;
        end
        return s;
    endfunction

    function automatic cbm_pkg::in_beat_t bus_cycle(logic op, logic cart_n,
                                                    logic slot2_n, logic slot1_n,
                                                    logic [cbm_pkg::ADDR_W-1:0] addr,
                                                    logic [cbm_pkg::DATA_W-1:0] data);
        cbm_pkg::in_beat_t b;
        b.op             = op;
        b.cart_select_n  = cart_n;
        b.slot2_select_n = slot2_n;
        b.slot1_select_n = slot1_n;
        b.bus_address    = addr;
        b.write_data     = data;
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // beat driving
    // ------------------------------------------------------------------------

    // sends one access beat, with a random gap in front of it
    task automatic send_access(cbm_pkg::in_beat_t b);
        cbm_pkg::in_beat_t item;
        while (!free_run && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        item = steer_off_blank(b);
        in_valid <= 1'b1;
        in_beat  <= item;
        do
            @(posedge clk);
        while (in_stall);
        // valid stays high here so a following beat can go back to back
        pending_lookups.push_back(map_access(item));
    endtask

    // holds the sender until every predicted lookup has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mapper enable is only written with the block idle
    task automatic write_mapper_enable(logic value);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mapper_on = value;
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // receiver stalls at random, except in the free running stretch
    always @(posedge clk)
        out_stall <= !free_run && ($urandom_range(0, 99) < IDLE_PERCENT);

    // compares each accepted result beat with the oldest predicted lookup
    always @(posedge clk)
    begin : check_results
        cbm_pkg::out_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_lookups.size() == 0)
                report_mismatch("result beat with no access waiting");
            else
            begin
                want = pending_lookups.pop_front();
                check_field("rom_read", 32'(out_beat.rom_read), 32'(want.rom_read));
                check_field("rom_address", 32'(out_beat.rom_address),
                            32'(want.rom_address));
                check_field("ram_read", 32'(out_beat.ram_read), 32'(want.ram_read));
                check_field("ram_data", 32'(out_beat.ram_data), 32'(want.ram_data));
            end
        end
    end

    // ends the run when no beat has moved on any channel for too long
    initial
    begin
        while (idle_count < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_count = 0;
            else
                idle_count++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // 32 kb cartridge: address masking, ignored writes and selects
    task automatic test_mapper_disabled();
        write_mapper_enable(1'b0);
        send_access(bus_cycle(cbm_pkg::OP_READ, 1'b0, 1'b0, 1'b1, 16'h0000, 8'h00));
        send_access(bus_cycle(cbm_pkg::OP_READ, 1'b0, 1'b0, 1'b1, 16'h7fff, 8'hff));
        // upper half folds back onto the 32 kb image
        send_access(bus_cycle(cbm_pkg::OP_READ, 1'b0, 1'b0, 1'b1, 16'hffff, 8'h00));
        send_access(bus_cycle(cbm_pkg::OP_READ, 1'b0, 1'b1, 1'b0, 16'hc000, 8'h00));
        // chip not selected
        send_access(bus_cycle(cbm_pkg::OP_READ, 1'b1, 1'b0, 1'b1, 16'h1234, 8'h00));
        // register write with the mapper off changes nothing
        send_access(bus_cycle(cbm_pkg::OP_WRITE, 1'b0, 1'b1, 1'b0, 16'hfffc, 8'hff));
        send_access(bus_cycle(cbm_pkg::OP_READ, 1'b0, 1'b0, 1'b0, 16'h4abc, 8'h00));
    endtask

    // paging, page offsets, ram window and register writes that hit ram
    task automatic test_bank_switching();
        write_mapper_enable(1'b1);
        send_access(bus_cycle(cbm_pkg::OP_READ, 1'b0, 1'b0, 1'b1, 16'h0000, 8'h00));
        send_access(bus_cycle(cbm_pkg::OP_READ, 1'b0, 1'b0, 1'b1, 16'h4001, 8'h00));
        send_access(bus_cycle(cbm_pkg::OP_READ, 1'b0, 1'b1, 1'b0, 16'h8000, 8'h00));
        send_access(bus_cycle(cbm_pkg::OP_WRITE, 1'b0, 1'b1, 1'b1, 16'hffff, 8'h3f));
        send_access(bus_cycle(cbm_pkg::OP_WRITE, 1'b0, 1'b1, 1'b1, 16'hfffd, 8'hff));
        // top of the largest rom
        send_access(bus_cycle(cbm_pkg::OP_READ, 1'b0, 1'b0, 1'b1, 16'h3fff, 8'h00));
        // each nonzero shift, with a page value that wraps
        send_access(bus_cycle(cbm_pkg::OP_WRITE, 1'b0, 1'b1, 1'b1, 16'hfffc, 8'h03));
        send_access(bus_cycle(cbm_pkg::OP_WRITE, 1'b0, 1'b1, 1'b1, 16'hfffe, 8'hfa));
        send_access(bus_cycle(cbm_pkg::OP_WRITE, 1'b0, 1'b1, 1'b1, 16'hfffc, 8'h01));
        send_access(bus_cycle(cbm_pkg::OP_WRITE, 1'b0, 1'b1, 1'b1, 16'hfffe, 8'h10));
        send_access(bus_cycle(cbm_pkg::OP_WRITE, 1'b0, 1'b1, 1'b1, 16'hfffc, 8'h02));
        send_access(bus_cycle(cbm_pkg::OP_WRITE, 1'b0, 1'b1, 1'b1, 16'hffff, 8'hf0));
        send_access(bus_cycle(cbm_pkg::OP_READ, 1'b0, 1'b1, 1'b0, 16'hbfff, 8'h00));
        // ram takes over the upper window
        send_access(bus_cycle(cbm_pkg::OP_WRITE, 1'b0, 1'b1, 1'b1, 16'hfffc, 8'h08));
        send_access(bus_cycle(cbm_pkg::OP_WRITE, 1'b0, 1'b1, 1'b0, 16'h8005, 8'ha5));
        send_access(bus_cycle(cbm_pkg::OP_READ, 1'b0, 1'b1, 1'b0, 16'h8005, 8'h00));
        // neither window selected
        send_access(bus_cycle(cbm_pkg::OP_READ, 1'b0, 1'b1, 1'b1, 16'h8005, 8'h00));
        // register write that also lands in ram
        send_access(bus_cycle(cbm_pkg::OP_WRITE, 1'b0, 1'b1, 1'b0, 16'hfffe, 8'h5c));
        send_access(bus_cycle(cbm_pkg::OP_READ, 1'b0, 1'b1, 1'b0, 16'hfffe, 8'h00));
        send_access(bus_cycle(cbm_pkg::OP_READ, 1'b0, 1'b0, 1'b1, 16'h4000, 8'h00));
        // write with the chip not selected is dropped
        send_access(bus_cycle(cbm_pkg::OP_WRITE, 1'b1, 1'b1, 1'b0, 16'hfffc, 8'h00));
        send_access(bus_cycle(cbm_pkg::OP_READ, 1'b0, 1'b1, 1'b0, 16'hc005, 8'h00));
    endtask

    // one random access, mostly well formed mapper traffic
    function automatic cbm_pkg::in_beat_t random_access();
        cbm_pkg::in_beat_t             b;
        int unsigned                   pick;
        logic [cbm_pkg::BANK_BITS-1:0] off;
        pick = $urandom_range(0, 99);
        // offsets cluster low and at the top so ram entries get reused
        case ($urandom_range(0, 3))
            0:       off = cbm_pkg::BANK_BITS'($urandom);
            1:       off = cbm_pkg::BANK_BITS'($urandom_range(0, 31));
            default: off = {9'h1ff, 5'($urandom_range(0, 31))};
        endcase
        b = bus_cycle(cbm_pkg::OP_READ, 1'b0, 1'b1, 1'b0, {2'b10, off},
                      cbm_pkg::DATA_W'($urandom));
        b.bus_address[cbm_pkg::BANK_BITS] = 1'($urandom);
        if (pick < 15)
        begin
            b.op             = cbm_pkg::OP_WRITE;
            b.slot2_select_n = 1'($urandom);
            b.slot1_select_n = 1'($urandom);
            b.bus_address    = cbm_pkg::MAPPER_REG_BASE
                               | cbm_pkg::ADDR_W'($urandom_range(0, 3));
        end
        else if (pick < 40)
            b.op = cbm_pkg::OP_WRITE;
        else if (pick < 55)
        begin
            b.slot2_select_n = 1'b0;
            b.slot1_select_n = 1'($urandom);
            b.bus_address[cbm_pkg::ADDR_W-1] = 1'b0;
        end
        else if (pick >= 85)
            b = cbm_pkg::in_beat_t'(($bits(cbm_pkg::in_beat_t))'($urandom));
        return b;
    endfunction

    // random phases, each under its own mapper setting
    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase < 2)
                write_mapper_enable(phase == 0);
            else
                write_mapper_enable(1'($urandom));
            for (int n = 0; n < 290; n++)
            begin
                send_access(random_access());
                // now and then let everything drain before going on
                if ($urandom_range(0, 199) == 0)
                    wait_for_results();
            end
        end
    endtask

    // back-to-back beats with no idle cycle on either side
    task automatic test_streaming();
        write_mapper_enable(1'b1);
        free_run = 1'b1;
        for (int n = 0; n < 300; n++)
            send_access(random_access());
        wait_for_results();
        free_run = 1'b0;
    endtask

    initial
    begin
        // mapper state after reset
        mapper_on   = 1'b0;
        control_reg = '0;
        page_reg[0] = 8'd0;
        page_reg[1] = 8'd1;
        page_reg[2] = 8'd2;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_mapper_disabled();
        test_bank_switching();
        test_random_traffic();
        test_streaming();
        wait_for_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
